[rtl/vcf_pkg.sv]
package vcf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int PROD_W    = 32;
    localparam int RESULT_W  = 40;
    localparam int CFG_W     = 5;
    localparam int TAP_IDX_W = 4;

    // action codes
    localparam logic ACT_LOAD_TAP = 1'b0;
    localparam logic ACT_SAMPLE   = 1'b1;

    localparam logic [CFG_W-1:0] KERNEL_TAPS_RST = 5'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TAP_W-1:0]    tap_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    typedef struct packed {
        logic shift;
        logic advance;
        logic tap_we;
    } cell_ctl_t;

endpackage

[rtl/vcf_cell.sv]
module vcf_cell import vcf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  sample_t   sample_in,
    input  tap_t      tap_wdata,
    input  sample_t   operand,
    output sample_t   sample_out,
    output prod_t     prod
);

    sample_t win_reg, win_next;
    tap_t    tap_reg, tap_next;
    prod_t   prod_reg, prod_next;

    always_comb begin
        win_next  = ctl.shift ? sample_in : win_reg;
        tap_next  = ctl.tap_we ? tap_wdata : tap_reg;
        // product taken with the tap as it stands when the sample arrives
        prod_next = ctl.advance ? prod_t'(operand) * prod_t'(tap_reg) : prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else begin
            tap_reg <= tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        prod_reg <= prod_next;
    end

    assign sample_out = win_reg;
    assign prod       = prod_reg;

endmodule

[rtl/valid_correlation_filter.sv]
// Streaming 1-D valid cross-correlation. One transaction (tap load or sample) is taken per
// clock while the result side keeps up. Each cell of the tap chain holds one kernel tap and
// one stored sample; samples shift along the chain and every cell forms its product in the
// cycle the sample is taken. From its sample a result passes through the product register,
// the registered sums of four products and the output register. The whole pipeline stalls
// while a result waits on m_ready. Results are Q8.8 x Q4.12 sums with 20 fraction bits.
module valid_correlation_filter import vcf_pkg::*; #(
    parameter int MAX_TAPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [TAP_IDX_W-1:0] s_tap_index,
    input  logic [TAP_W-1:0]     s_tap_value,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic                 s_last_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RESULT_W-1:0]  m_result,
    output logic                 m_last_result
);

    localparam int KW = $clog2(MAX_TAPS + 1);
    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NG = (MAX_TAPS + 3) / 4;

    logic [CFG_W-1:0] kernel_taps_reg, kernel_taps_next;
    logic [KW-1:0]    fill_count_reg, fill_count_next;
    logic [KW-1:0]    k_eff;
    logic [KW:0]      seen;
    logic             emit;

    logic advance, acc_sample, acc_load;

    cell_ctl_t ctl     [MAX_TAPS];
    sample_t   win     [MAX_TAPS];
    sample_t   operand [MAX_TAPS];
    prod_t     prod    [MAX_TAPS];

    logic    p_valid_reg, p_valid_next, p_last_reg, p_last_next;
    logic    g_valid_reg, g_valid_next, g_last_reg, g_last_next;
    result_t grp_reg [NG];
    result_t grp_next [NG];
    logic    o_valid_reg, o_valid_next, o_last_reg, o_last_next;
    result_t result_reg, result_next;
    result_t total;

    assign advance    = !o_valid_reg || m_ready;
    assign s_ready    = advance;
    assign acc_sample = s_valid && advance && (s_action == ACT_SAMPLE);
    assign acc_load   = s_valid && advance && (s_action == ACT_LOAD_TAP);

    // zero taps counts as one, anything above the chain length as the full chain
    always_comb begin
        if (kernel_taps_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(kernel_taps_reg) > MAX_TAPS) begin
            k_eff = KW'(MAX_TAPS);
        end else begin
            k_eff = KW'(kernel_taps_reg);
        end
    end

    assign seen = {1'b0, fill_count_reg} + (KW+1)'(1);
    assign emit = seen >= {1'b0, k_eff};

    always_comb begin
        kernel_taps_next = cfg_we ? cfg_wdata : kernel_taps_reg;
        fill_count_next  = fill_count_reg;
        if (acc_sample) begin
            if (s_last_sample) begin
                fill_count_next = '0;
            end else if (int'(seen) > MAX_TAPS) begin
                fill_count_next = KW'(MAX_TAPS);
            end else begin
                fill_count_next = seen[KW-1:0];
            end
        end
    end

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_chain
        // tap j meets the sample that arrived k-1-j samples ago
        always_comb begin
            if (int'(k_eff) == j + 1) begin
                operand[j] = sample_t'(s_sample);
            end else if (int'(k_eff) > j + 1) begin
                operand[j] = win[IW'(int'(k_eff) - 2 - j)];
            end else begin
                operand[j] = '0;
            end
        end

        always_comb begin
            ctl[j].shift   = acc_sample;
            ctl[j].advance = advance;
            ctl[j].tap_we  = acc_load && (int'(s_tap_index) == j);
        end

        if (j == 0) begin : g_head
            vcf_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl[j]),
                .sample_in  (sample_t'(s_sample)),
                .tap_wdata  (tap_t'(s_tap_value)),
                .operand    (operand[j]),
                .sample_out (win[j]),
                .prod       (prod[j])
            );
        end else begin : g_body
            vcf_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl[j]),
                .sample_in  (win[j-1]),
                .tap_wdata  (tap_t'(s_tap_value)),
                .operand    (operand[j]),
                .sample_out (win[j]),
                .prod       (prod[j])
            );
        end
    end

    // sums of four neighbouring products
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_next[g] = grp_reg[g];
            if (advance) begin
                grp_next[g] = '0;
                for (int i = 0; i < 4; i++) begin
                    if (4 * g + i < MAX_TAPS) begin
                        grp_next[g] = grp_next[g] + result_t'(prod[4 * g + i]);
                    end
                end
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NG; g++) begin
            total = total + grp_reg[g];
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        p_last_next  = p_last_reg;
        g_valid_next = g_valid_reg;
        g_last_next  = g_last_reg;
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;
        result_next  = result_reg;
        if (advance) begin
            p_valid_next = acc_sample && emit;
            p_last_next  = s_last_sample;
            g_valid_next = p_valid_reg;
            g_last_next  = p_last_reg;
            o_valid_next = g_valid_reg;
            o_last_next  = g_last_reg;
            result_next  = total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_taps_reg <= KERNEL_TAPS_RST;
            fill_count_reg  <= '0;
            p_valid_reg     <= 1'b0;
            g_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
        end else begin
            kernel_taps_reg <= kernel_taps_next;
            fill_count_reg  <= fill_count_next;
            p_valid_reg     <= p_valid_next;
            g_valid_reg     <= g_valid_next;
            o_valid_reg     <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_last_reg <= p_last_next;
        g_last_reg <= g_last_next;
        o_last_reg <= o_last_next;
        result_reg <= result_next;
        for (int g = 0; g < NG; g++) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    assign m_valid       = o_valid_reg;
    assign m_result      = result_reg;
    assign m_last_result = o_last_reg;

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_count_reg) <= MAX_TAPS)
        else $error("fill count beyond chain length");

    a_keff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (k_eff != '0) && (int'(k_eff) <= MAX_TAPS))
        else $error("taps in use out of range");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_load |=> !p_valid_reg)
        else $error("tap load produced a result");

    a_full_window_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_sample && emit) |=> p_valid_reg)
        else $error("full window transaction lost its result");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_sample && s_last_sample) |=> (fill_count_reg == '0))
        else $error("vector end did not clear the count");

endmodule

[tb/sv/valid_correlation_filter_test.sv]
`timescale 1ns / 1ps

module valid_correlation_filter_test;
    import vcf_pkg::*;

    localparam int MAX_TAPS     = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 1750;

    typedef struct {
        result_t sum;
        logic    last;
    } corr_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_LOAD_TAP;
    logic [TAP_IDX_W-1:0] s_tap_index = '0;
    logic [TAP_W-1:0]     s_tap_value = '0;
    logic [SAMPLE_W-1:0]  s_sample = '0;
    logic                 s_last_sample = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RESULT_W-1:0]  m_result;
    logic                 m_last_result;

    // predictor state
    logic [CFG_W-1:0] k_model;
    sample_t          win_model [MAX_TAPS-1];
    tap_t             tap_model [MAX_TAPS];
    int               fill_model;

    corr_out_t pending_sums [$];
    int        items_sent;
    int        fault_count;
    logic      steady;

    valid_correlation_filter #(.MAX_TAPS(MAX_TAPS)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_tap_index   (s_tap_index),
        .s_tap_value   (s_tap_value),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_last_result (m_last_result)
    );

    always #4 aclk = ~aclk;

    function automatic int taps_active();
        if (k_model == 0)
            return 1;
        if (k_model > MAX_TAPS)
            return MAX_TAPS;
        return int'(k_model);
    endfunction

    function automatic void clear_model();
        k_model = KERNEL_TAPS_RST;
        fill_model = 0;
        foreach (win_model[i])
            win_model[i] = '0;
        foreach (tap_model[i])
            tap_model[i] = '0;
    endfunction

    // expected sum for one accepted transaction, queued when a result is due
    function automatic void correlate_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                                           input tap_t tv, input sample_t smp, input logic lst);
        int                 k;
        int                 seen;
        logic signed [63:0] acc;
        sample_t            s;
        corr_out_t          r;
        if (act == ACT_LOAD_TAP) begin
            if (idx < MAX_TAPS)
                tap_model[idx] = tv;
            return;
        end
        k = taps_active();
        seen = fill_model + 1;
        if (seen >= k) begin
            acc = '0;
            for (int j = 0; j < k; j++) begin
                s = (j == k - 1) ? smp : win_model[k - 2 - j];
                acc += longint'(s) * longint'(tap_model[j]);
            end
            r.sum = acc[RESULT_W-1:0];
            r.last = lst;
            pending_sums.push_back(r);
        end
        for (int j = MAX_TAPS - 2; j > 0; j--)
            win_model[j] = win_model[j - 1];
        win_model[0] = smp;
        if (lst)
            fill_model = 0;
        else
            fill_model = (seen > MAX_TAPS) ? MAX_TAPS : seen;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // result checker
    always @(posedge aclk) begin
        corr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result transaction: result %0d", $signed(m_result));
                fault_count++;
            end else begin
                want = pending_sums.pop_front();
                if (m_result !== want.sum) begin
                    $error("result: expected %0d, actual %0d", want.sum, $signed(m_result));
                    fault_count++;
                end
                if (m_last_result !== want.last) begin
                    $error("last_result: expected %0b, actual %0b", want.last, m_last_result);
                    fault_count++;
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                             input logic [15:0] tv, input logic [15:0] smp, input logic lst);
        if (!steady) begin
            while ($urandom_range(0, 99) < 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_tap_index   <= idx;
        s_tap_value   <= tv;
        s_sample      <= smp;
        s_last_sample <= lst;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
        correlate_item(act, idx, tap_t'(tv), sample_t'(smp), lst);
    endtask

    task automatic load_tap(input int idx, input logic [15:0] val);
        send_item(ACT_LOAD_TAP, idx[TAP_IDX_W-1:0], val, rand_word(), 1'($urandom));
    endtask

    task automatic push_sample(input logic [15:0] val, input logic lst);
        send_item(ACT_SAMPLE, TAP_IDX_W'($urandom), rand_word(), val, lst);
    endtask

    // hold the sender until every result is out and the pipeline has emptied
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_kernel_taps(input logic [CFG_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        k_model = val;
    endtask

    task automatic load_random_taps(input int count);
        for (int i = 0; i < count; i++)
            load_tap($urandom_range(0, MAX_TAPS - 1), rand_word());
    endtask

    task automatic run_vector(input int len, input int load_pct);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < load_pct)
                load_tap($urandom_range(0, MAX_TAPS - 1), rand_word());
            push_sample(rand_word(), i == len - 1);
        end
    endtask

    task automatic test_reset_state();
        // reset kernel of three zero taps
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0001, 1'b1);
    endtask

    task automatic test_extreme_values();
        set_kernel_taps(5'd2);
        // last flag on a tap load has no effect
        send_item(ACT_LOAD_TAP, 4'd0, 16'h8000, 16'h7fff, 1'b1);
        send_item(ACT_LOAD_TAP, 4'd1, 16'h7fff, 16'h8000, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b1);
    endtask

    task automatic test_short_vector();
        push_sample(16'h0005, 1'b1);
    endtask

    task automatic test_tap_load_mid_vector();
        push_sample(16'h0100, 1'b0);
        push_sample(16'h0200, 1'b0);
        load_tap(1, 16'h1000);
        push_sample(16'hff00, 1'b1);
    endtask

    task automatic test_kernel_taps_clamp();
        set_kernel_taps(5'd0);
        push_sample(16'h0007, 1'b0);
        push_sample(16'hfffd, 1'b1);
        set_kernel_taps(5'd31);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h0002, 1'b0);
        push_sample(16'h0003, 1'b1);
    endtask

    task automatic test_kernel_change_mid_vector();
        push_sample(16'h0011, 1'b0);
        push_sample(16'h0022, 1'b0);
        push_sample(16'h0033, 1'b0);
        set_kernel_taps(5'd2);
        push_sample(16'h0044, 1'b1);
    endtask

    task automatic test_config_sweep();
        logic [CFG_W-1:0] sweep [10] = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31,
                                         5'd8, 5'd4, 5'd15, 5'd10, 5'd21};
        foreach (sweep[i]) begin
            set_kernel_taps(sweep[i]);
            load_random_taps(taps_active());
            repeat (3) run_vector($urandom_range(taps_active(), taps_active() + 8), 3);
        end
    endtask

    task automatic test_full_rate();
        set_kernel_taps(5'd16);
        steady = 1'b1;
        for (int i = 0; i < MAX_TAPS; i++)
            load_tap(i, rand_word());
        run_vector(200, 0);
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int pick;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                set_kernel_taps(CFG_W'($urandom));
            else if (pick < 7)
                settle();
            else if (pick < 20)
                load_random_taps($urandom_range(1, 8));
            else if (pick < 90) begin
                if ($urandom_range(0, 9) == 0)
                    run_vector($urandom_range(1, taps_active()), 5);
                else
                    run_vector($urandom_range(taps_active(), taps_active() + 16), 5);
            end else begin
                // unstructured transactions
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom), TAP_IDX_W'($urandom), rand_word(), rand_word(),
                              1'($urandom));
            end
        end
    endtask

    initial begin
        items_sent  = 0;
        fault_count = 0;
        steady      = 1'b0;
        clear_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_extreme_values();
        test_short_vector();
        test_tap_load_mid_vector();
        test_kernel_taps_clamp();
        test_kernel_change_mid_vector();
        test_config_sweep();
        test_full_rate();
        test_random_traffic();

        settle();
        if (fault_count == 0)
            $display("valid_correlation_filter regression: pass");
        else
            $display("valid_correlation_filter regression: fail");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("valid_correlation_filter regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/vcf_pkg.sv
rtl/vcf_cell.sv
rtl/valid_correlation_filter.sv
tb/sv/valid_correlation_filter_test.sv
